/* sv/tpsc_pkg.sv */
// shared types and constants for the treadmill position/speed command block
// no dependencies; used by the channel interfaces and the top level
`default_nettype none

package tpsc_pkg;

	typedef logic signed [13:0] pos_t;
	typedef logic [12:0] depth_t;
	typedef logic [11:0] limit_t;
	typedef logic [15:0] pwm_t;
	typedef logic [7:0] byte_t;
	typedef logic signed [31:0] vel_t;

	// register indexes of the configuration port
	typedef logic [2:0] reg_idx_t;
	localparam reg_idx_t REG_HOME_DISTANCE = 3'd0;
	localparam reg_idx_t REG_SIDE_LIMIT = 3'd1;
	localparam reg_idx_t REG_DEPTH_LIMIT = 3'd2;
	localparam reg_idx_t REG_DEAD_BAND = 3'd3;
	localparam reg_idx_t REG_MIN_PWM = 3'd4;
	localparam int CFG_DATA_W = 16;

	localparam depth_t HOME_DISTANCE_RST = 13'd2700;
	localparam limit_t SIDE_LIMIT_RST = 12'd270;
	localparam limit_t DEPTH_LIMIT_RST = 12'd650;
	localparam limit_t DEAD_BAND_RST = 12'd135;
	localparam pwm_t MIN_PWM_RST = 16'd4000;

	typedef enum logic [1:0] {
		SIGN_NONE = 2'd0,
		SIGN_POS = 2'd1,
		SIGN_NEG = 2'd2
	} sign_t;

	// frame codes on the serial link
	localparam byte_t FRAME_SPEED = 8'd1;
	localparam byte_t FRAME_DIR = 8'd2;
	localparam byte_t DIR_FWD = 8'd2;
	localparam byte_t DIR_BACK = 8'd1;
	localparam byte_t BYTE_ZERO = 8'd0;

	// velocity is carried as 64x the speed in 1/5000 m/s
	localparam depth_t LIN_LIMIT = 13'd400;
	localparam vel_t LIN_GAIN = 32'sd6000;
	localparam vel_t CREEP_V64 = 32'sd3200;
	localparam vel_t OFFSET_V64 = 32'sd160000;

	localparam int FRAME_BYTES = 5;
	typedef logic [2:0] byte_idx_t;
	localparam byte_idx_t IDX_LAST_SHORT = 3'd2;
	localparam byte_idx_t IDX_LAST_LONG = 3'd4;

endpackage

`default_nettype wire

/* sv/tpsc_pose_if.sv */
// valid/ready channel carrying one torso position sample
// depends on tpsc_pkg
`default_nettype none

interface tpsc_pose_if;
	logic valid;
	logic ready;
	tpsc_pkg::pos_t torso_x_mm;
	tpsc_pkg::pos_t torso_y_mm;
	tpsc_pkg::depth_t torso_z_mm;

	modport source (output valid, output torso_x_mm, output torso_y_mm, output torso_z_mm,
		input ready);
	modport sink (input valid, input torso_x_mm, input torso_y_mm, input torso_z_mm,
		output ready);
endinterface

`default_nettype wire

/* sv/tpsc_cmd_if.sv */
// valid/ready channel carrying one serial command byte
// depends on tpsc_pkg
`default_nettype none

interface tpsc_cmd_if;
	logic valid;
	logic ready;
	tpsc_pkg::byte_t tx_byte;
	logic last_byte;

	modport source (output valid, output tx_byte, output last_byte, input ready);
	modport sink (input valid, input tx_byte, input last_byte, output ready);
endinterface

`default_nettype wire

/* sv/treadmill_position_speed_command.sv */
// treadmill speed command: torso sample in, serial command bytes out
// depends on tpsc_pkg, tpsc_pose_if, tpsc_cmd_if
//
//  port    dir  beat                                   handshake
//  pose    in   torso_x_mm, torso_y_mm, torso_z_mm     valid/ready
//  cmd     out  tx_byte, last_byte                     valid/ready
//  cfg     in   cfg_index, cfg_data                    cfg_we, no back-pressure
//
// a pose beat lands in the input register; combinational logic builds the
// whole frame (3 or 5 bytes) into the frame register, which then sends one byte
// per cycle while cmd.ready is high; the input register takes the next sample
// while the current frame drains
// arst_n clears valids, the sign memory and the configuration to defaults
`default_nettype none

module treadmill_position_speed_command (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire tpsc_pkg::reg_idx_t cfg_index,
	input wire logic [tpsc_pkg::CFG_DATA_W-1:0] cfg_data,
	tpsc_pose_if.sink pose,
	tpsc_cmd_if.source cmd
);

	// configuration
	tpsc_pkg::depth_t home_q;
	tpsc_pkg::limit_t side_q;
	tpsc_pkg::limit_t depth_q;
	tpsc_pkg::limit_t dead_q;
	tpsc_pkg::pwm_t min_pwm_q;

	// input stage
	logic valid_s1;
	tpsc_pkg::pos_t x_s1;
	tpsc_pkg::pos_t y_s1;
	tpsc_pkg::depth_t z_s1;

	// frame register and sign memory
	tpsc_pkg::sign_t sign_q;
	logic fvalid_q;
	logic long_q;
	tpsc_pkg::byte_idx_t idx_q;
	tpsc_pkg::byte_t bytes_q [tpsc_pkg::FRAME_BYTES];

	logic take, at_last, load;

	// frame logic
	logic signed [13:0] d;
	tpsc_pkg::depth_t ad;
	logic signed [27:0] prod;
	tpsc_pkg::vel_t prod_ext, v_lin, v_quad, v_raw, v64, vs, vs_abs, sum, w;
	logic [13:0] x_abs;
	logic outside, in_dead, send_dir;
	tpsc_pkg::pwm_t pwm_sat, pwm;
	tpsc_pkg::sign_t sign_next;
	tpsc_pkg::byte_t frame [tpsc_pkg::FRAME_BYTES];
	logic frame_long;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			home_q <= tpsc_pkg::HOME_DISTANCE_RST;
			side_q <= tpsc_pkg::SIDE_LIMIT_RST;
			depth_q <= tpsc_pkg::DEPTH_LIMIT_RST;
			dead_q <= tpsc_pkg::DEAD_BAND_RST;
			min_pwm_q <= tpsc_pkg::MIN_PWM_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				tpsc_pkg::REG_HOME_DISTANCE: home_q <= cfg_data[12:0];
				tpsc_pkg::REG_SIDE_LIMIT: side_q <= cfg_data[11:0];
				tpsc_pkg::REG_DEPTH_LIMIT: depth_q <= cfg_data[11:0];
				tpsc_pkg::REG_DEAD_BAND: dead_q <= cfg_data[11:0];
				tpsc_pkg::REG_MIN_PWM: min_pwm_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign take = fvalid_q && cmd.ready;
	assign at_last = long_q ? (idx_q == tpsc_pkg::IDX_LAST_LONG)
		: (idx_q == tpsc_pkg::IDX_LAST_SHORT);
	assign load = valid_s1 && (!fvalid_q || (take && at_last));
	assign pose.ready = !valid_s1 || load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pose.valid && pose.ready) begin
			valid_s1 <= 1'b1;
		end else if (load) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pose.valid && pose.ready) begin
			x_s1 <= pose.torso_x_mm;
			y_s1 <= pose.torso_y_mm;
			z_s1 <= pose.torso_z_mm;
		end
	end

	always_comb begin
		d = $signed({1'b0, home_q}) - $signed({1'b0, z_s1});
		ad = d[13] ? 13'(-d) : 13'(d);
		prod = d * $signed({1'b0, ad});
		prod_ext = 32'(prod);
		v_quad = (prod_ext <<< 4) - prod_ext;
		v_lin = 32'(32'(d) * tpsc_pkg::LIN_GAIN);
		v_raw = (ad <= tpsc_pkg::LIN_LIMIT) ? v_lin : v_quad;

		// a sign reversal is softened to a creep in the new direction
		v64 = v_raw;
		if (sign_q == tpsc_pkg::SIGN_NEG && v_raw > 0) begin
			v64 = tpsc_pkg::CREEP_V64;
		end else if (sign_q == tpsc_pkg::SIGN_POS && v_raw < 0) begin
			v64 = -tpsc_pkg::CREEP_V64;
		end

		if (v64 > 0) begin
			sign_next = tpsc_pkg::SIGN_POS;
		end else if (v64 < 0) begin
			sign_next = tpsc_pkg::SIGN_NEG;
		end else begin
			sign_next = tpsc_pkg::SIGN_NONE;
		end

		x_abs = x_s1[13] ? 14'(-x_s1) : 14'(x_s1);
		outside = (x_abs > {2'b00, side_q}) || (ad > {1'b0, depth_q}) || y_s1[13];
		in_dead = ad < {1'b0, dead_q};

		if (!in_dead) begin
			vs = v64;
		end else if (sign_q == tpsc_pkg::SIGN_NEG) begin
			vs = -tpsc_pkg::CREEP_V64;
		end else begin
			vs = tpsc_pkg::CREEP_V64;
		end

		vs_abs = vs[31] ? -vs : vs;
		send_dir = vs_abs > tpsc_pkg::CREEP_V64;

		sum = vs + tpsc_pkg::OFFSET_V64;
		w = sum[31] ? -sum : sum;
		pwm_sat = (|w[30:22]) ? '1 : w[21:6];
		pwm = (pwm_sat < min_pwm_q) ? min_pwm_q : pwm_sat;

		for (int i = 0; i < tpsc_pkg::FRAME_BYTES; i++) begin
			frame[i] = tpsc_pkg::BYTE_ZERO;
		end
		frame_long = 1'b0;
		if (outside) begin
			frame[0] = tpsc_pkg::FRAME_SPEED;
		end else if (send_dir) begin
			frame_long = 1'b1;
			frame[0] = tpsc_pkg::FRAME_DIR;
			frame[1] = vs[31] ? tpsc_pkg::DIR_BACK : tpsc_pkg::DIR_FWD;
			frame[2] = tpsc_pkg::FRAME_SPEED;
			frame[3] = pwm[15:8];
			frame[4] = pwm[7:0];
		end else begin
			frame[0] = tpsc_pkg::FRAME_SPEED;
			frame[1] = pwm[15:8];
			frame[2] = pwm[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sign_q <= tpsc_pkg::SIGN_NONE;
			fvalid_q <= 1'b0;
			idx_q <= '0;
			long_q <= 1'b0;
		end else if (load) begin
			sign_q <= sign_next;
			fvalid_q <= 1'b1;
			idx_q <= '0;
			long_q <= frame_long;
		end else if (take) begin
			if (at_last) begin
				fvalid_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bytes_q <= frame;
		end
	end

	assign cmd.valid = fvalid_q;
	assign cmd.tx_byte = bytes_q[idx_q];
	assign cmd.last_byte = at_last;

endmodule

`default_nettype wire

/* test/tb_top.sv */
// testbench for treadmill_position_speed_command: directed pose table, then random phases
// depends on tpsc_pkg, tpsc_pose_if, tpsc_cmd_if and the block itself
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import tpsc_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned DRAIN_LIMIT = 4000;
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned N_PHASES = 6;
	localparam int unsigned ITEMS_PER_PHASE = 85;
	localparam longint LIN_SPAN = 400;
	localparam longint QUAD_GAIN = 15;
	localparam longint PWM_MAX = 65535;

	// typed frames, first byte in the top bits
	localparam logic [39:0] STOP_FRAME = {FRAME_SPEED, BYTE_ZERO, BYTE_ZERO, 16'h0};
	localparam logic [39:0] HOME_CREEP_FRAME = {FRAME_SPEED, 8'h0F, 8'hA0, 16'h0};

	typedef struct packed {
		pos_t x;
		pos_t y;
		depth_t z;
		logic [2:0] typed_n;
		logic [39:0] typed_frame;
	} pose_row_t;

	typedef struct packed {
		byte_t data;
		logic last;
	} cmd_beat_t;

	localparam int N_DIRECTED = 23;
	localparam pose_row_t DIRECTED [N_DIRECTED] = '{
		'{14'sd0, 14'sd0, 13'd2700, 3'd3, HOME_CREEP_FRAME},
		'{14'sd0, -14'sd1, 13'd2700, 3'd3, STOP_FRAME},
		'{14'sd271, 14'sd0, 13'd2700, 3'd3, STOP_FRAME},
		'{-14'sd271, 14'sd0, 13'd2700, 3'd3, STOP_FRAME},
		'{14'sd270, 14'sd0, 13'd2700, 3'd0, 40'h0},
		'{-14'sd8192, 14'sd8191, 13'd2700, 3'd3, STOP_FRAME},
		'{14'sd8191, 14'sd0, 13'd2700, 3'd3, STOP_FRAME},
		'{14'sd0, -14'sd8192, 13'd2700, 3'd3, STOP_FRAME},
		'{14'sd0, 14'sd0, 13'd0, 3'd3, STOP_FRAME},
		'{14'sd0, 14'sd0, 13'd8191, 3'd3, STOP_FRAME},
		'{14'sd0, 14'sd0, 13'd2565, 3'd0, 40'h0},
		'{14'sd0, 14'sd0, 13'd2300, 3'd0, 40'h0},
		'{14'sd0, 14'sd0, 13'd2299, 3'd0, 40'h0},
		'{14'sd0, 14'sd0, 13'd2050, 3'd0, 40'h0},
		'{14'sd0, 14'sd0, 13'd2049, 3'd3, STOP_FRAME},
		'{14'sd0, 14'sd100, 13'd3100, 3'd0, 40'h0},
		'{14'sd0, 14'sd100, 13'd3100, 3'd0, 40'h0},
		'{14'sd0, 14'sd8191, 13'd3350, 3'd0, 40'h0},
		'{14'sd0, 14'sd0, 13'd3351, 3'd3, STOP_FRAME},
		'{-14'sd270, 14'sd0, 13'd2834, 3'd0, 40'h0},
		'{14'sd0, 14'sd0, 13'd2700, 3'd0, 40'h0},
		'{14'sd0, 14'sd0, 13'd2566, 3'd0, 40'h0},
		'{-14'sd270, 14'sd0, 13'd2565, 3'd0, 40'h0}
	};

	logic clk;
	logic arst_n;
	logic cfg_we;
	reg_idx_t cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	tpsc_pose_if pose_ch();
	tpsc_cmd_if cmd_ch();

	treadmill_position_speed_command dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.pose(pose_ch),
		.cmd(cmd_ch)
	);

	// predictor copy of the registers and the sign memory
	depth_t home_mm;
	limit_t side_mm;
	limit_t depth_mm;
	limit_t dead_mm;
	pwm_t min_code;
	sign_t speed_sign;

	cmd_beat_t pending_beats[$];
	int unsigned errors;
	int unsigned cycles;
	int unsigned samples_sent;
	int unsigned beats_seen;
	int unsigned settings_used;
	int unsigned src_idle_pct;
	int unsigned snk_idle_pct;

	task automatic flag(input string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		errors++;
	endtask

	// bytes sent for one pose sample; also advances the sign memory
	function automatic int unsigned build_frame(input pos_t x, input pos_t y, input depth_t z,
			output byte_t frame [FRAME_BYTES]);
		longint d;
		longint ad;
		longint ax;
		longint v;
		longint drive;
		longint w;
		longint pwm;
		sign_t prev;
		int unsigned n;
		d = longint'(home_mm) - longint'(z);
		ad = d < 0 ? -d : d;
		ax = longint'(x) < 0 ? -longint'(x) : longint'(x);
		v = ad <= LIN_SPAN ? longint'(LIN_GAIN) * d : QUAD_GAIN * d * ad;
		prev = speed_sign;
		// a reversal against the last motion only creeps the other way
		if (prev == SIGN_NEG && v > 0)
			v = CREEP_V64;
		else if (prev == SIGN_POS && v < 0)
			v = -CREEP_V64;
		for (int i = 0; i < FRAME_BYTES; i++)
			frame[i] = BYTE_ZERO;
		n = 0;
		if (ax > longint'(side_mm) || ad > longint'(depth_mm) || y < 0) begin
			frame[0] = FRAME_SPEED;
			n = 3;
		end else begin
			if (ad >= longint'(dead_mm))
				drive = v;
			else
				drive = prev == SIGN_NEG ? -CREEP_V64 : CREEP_V64;
			if ((drive < 0 ? -drive : drive) > CREEP_V64) begin
				frame[0] = FRAME_DIR;
				frame[1] = drive >= 0 ? DIR_FWD : DIR_BACK;
				n = 2;
			end
			w = drive + OFFSET_V64;
			w = w < 0 ? -w : w;
			pwm = w / 64;
			if (pwm > PWM_MAX)
				pwm = PWM_MAX;
			if (pwm < longint'(min_code))
				pwm = min_code;
			frame[n] = FRAME_SPEED;
			frame[n + 1] = pwm[15:8];
			frame[n + 2] = pwm[7:0];
			n = n + 3;
		end
		speed_sign = v > 0 ? SIGN_POS : (v < 0 ? SIGN_NEG : SIGN_NONE);
		return n;
	endfunction

	task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_HOME_DISTANCE: home_mm = value[12:0];
			REG_SIDE_LIMIT: side_mm = value[11:0];
			REG_DEPTH_LIMIT: depth_mm = value[11:0];
			REG_DEAD_BAND: dead_mm = value[11:0];
			REG_MIN_PWM: min_code = value;
			default: ;
		endcase
	endtask

	task automatic apply_settings(input int unsigned home, input int unsigned side,
			input int unsigned depth, input int unsigned dead, input int unsigned minp);
		write_reg(REG_HOME_DISTANCE, CFG_DATA_W'(home));
		write_reg(REG_SIDE_LIMIT, CFG_DATA_W'(side));
		write_reg(REG_DEPTH_LIMIT, CFG_DATA_W'(depth));
		write_reg(REG_DEAD_BAND, CFG_DATA_W'(dead));
		write_reg(REG_MIN_PWM, CFG_DATA_W'(minp));
		settings_used++;
	endtask

	// drive one pose beat, then queue the bytes it should produce
	task automatic send_pose(input pos_t x, input pos_t y, input depth_t z,
			input logic [2:0] typed_n, input logic [39:0] typed_frame);
		byte_t frame [FRAME_BYTES];
		int unsigned n;
		@(negedge clk);
		while (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
			pose_ch.valid <= 1'b0;
			@(negedge clk);
		end
		pose_ch.valid <= 1'b1;
		pose_ch.torso_x_mm <= x;
		pose_ch.torso_y_mm <= y;
		pose_ch.torso_z_mm <= z;
		do
			@(posedge clk);
		while (!pose_ch.ready);
		n = build_frame(x, y, z, frame);
		if (typed_n != 0) begin
			n = typed_n;
			for (int i = 0; i < FRAME_BYTES; i++)
				frame[i] = typed_frame[39 - 8 * i -: 8];
		end
		for (int unsigned i = 0; i < n; i++)
			pending_beats.push_back('{data: frame[i], last: (i == n - 1)});
		samples_sent++;
	endtask

	// mostly in-zone samples around home; a fifth are raw noise
	task automatic random_pose();
		logic [31:0] rnd;
		int d;
		int zi;
		pos_t x;
		pos_t y;
		depth_t z;
		if ($urandom_range(0, 9) < 2) begin
			rnd = $urandom();
			x = rnd[13:0];
			rnd = $urandom();
			y = rnd[13:0];
			rnd = $urandom();
			z = rnd[12:0];
		end else begin
			x = pos_t'(int'($urandom_range(0, 2 * side_mm)) - int'(side_mm));
			y = pos_t'($urandom_range(0, 8191));
			case ($urandom_range(0, 3))
				0: d = $urandom_range(0, dead_mm);
				1: d = $urandom_range(395, 405);
				default: d = $urandom_range(0, depth_mm);
			endcase
			if ($urandom_range(0, 1) != 0)
				d = -d;
			zi = int'(home_mm) - d;
			if (zi < 0)
				zi = 0;
			if (zi > 8191)
				zi = 8191;
			z = depth_t'(zi);
		end
		send_pose(x, y, z, 3'd0, 40'h0);
	endtask

	task automatic drain_frames();
		int unsigned waited;
		@(negedge clk);
		pose_ch.valid <= 1'b0;
		waited = 0;
		while (pending_beats.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (pending_beats.size() != 0) begin
			flag($sformatf("%0d command bytes never arrived", pending_beats.size()));
			pending_beats.delete();
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d bytes outstanding", cycles,
				pending_beats.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	always @(negedge clk)
		cmd_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);

	always @(posedge clk) begin
		cmd_beat_t want;
		if (arst_n && cmd_ch.valid && cmd_ch.ready) begin
			beats_seen++;
			if (pending_beats.size() == 0) begin
				flag($sformatf("unexpected byte %h last %b", cmd_ch.tx_byte, cmd_ch.last_byte));
			end else begin
				want = pending_beats.pop_front();
				if (cmd_ch.tx_byte !== want.data)
					flag($sformatf("tx_byte %h, expected %h", cmd_ch.tx_byte, want.data));
				if (cmd_ch.last_byte !== want.last)
					flag($sformatf("last_byte %b, expected %b on byte %h",
						cmd_ch.last_byte, want.last, want.data));
			end
		end
	end

	initial begin
		errors = 0;
		cycles = 0;
		samples_sent = 0;
		beats_seen = 0;
		settings_used = 1;
		src_idle_pct = 6;
		snk_idle_pct = 85;
		home_mm = HOME_DISTANCE_RST;
		side_mm = SIDE_LIMIT_RST;
		depth_mm = DEPTH_LIMIT_RST;
		dead_mm = DEAD_BAND_RST;
		min_code = MIN_PWM_RST;
		speed_sign = SIGN_NONE;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_HOME_DISTANCE;
		cfg_data = '0;
		pose_ch.valid = 1'b0;
		pose_ch.torso_x_mm = '0;
		pose_ch.torso_y_mm = '0;
		pose_ch.torso_z_mm = '0;
		cmd_ch.ready = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int r = 0; r < N_DIRECTED; r++)
			send_pose(DIRECTED[r].x, DIRECTED[r].y, DIRECTED[r].z,
				DIRECTED[r].typed_n, DIRECTED[r].typed_frame);

		for (int unsigned p = 0; p < N_PHASES; p++) begin
			if (p < 2) begin
				src_idle_pct = 6;
				snk_idle_pct = 85;
			end else if (p < 4) begin
				src_idle_pct = 85;
				snk_idle_pct = 6;
			end else begin
				src_idle_pct = 0;
				snk_idle_pct = 0;
			end
			// phase 0 keeps the reset settings
			if (p != 0) begin
				drain_frames();
				case (p)
					1: apply_settings(8191, 4095, 4095, 0, 0);
					2: apply_settings(0, 0, 0, 0, 65535);
					3: apply_settings(4000, 1000, 4095, 4095, 100);
					default: begin
						int unsigned depth;
						depth = $urandom_range(0, 4095);
						apply_settings($urandom_range(0, 8191), $urandom_range(0, 4095), depth,
							$urandom_range(0, depth), $urandom_range(0, 65535));
					end
				endcase
			end
			for (int unsigned i = 0; i < ITEMS_PER_PHASE; i++)
				random_pose();
		end

		drain_frames();
		$display("sent %0d pose samples and checked %0d command bytes", samples_sent, beats_seen);
		$display("covered %0d register settings under three idle patterns", settings_used);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

/* treadmill_position_speed_command.f */
sv/tpsc_pkg.sv
sv/tpsc_pose_if.sv
sv/tpsc_cmd_if.sv
sv/treadmill_position_speed_command.sv
test/tb_top.sv
